// ----- hw/rtl/rmq_pkg.sv -----
package rmq_pkg;

  localparam int CAPACITY   = 1024;
  localparam int BLOCK_SIZE = 32;
  localparam int VAL_W      = 32;

  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = IDX_W + 1;
  localparam int MW         = $clog2(BLOCK_SIZE);
  localparam int MAX_BLOCKS = CAPACITY / BLOCK_SIZE;
  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int NB_W       = BLK_W + 1;
  localparam int LEVELS     = BLK_W + 1;
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int TBL_DEPTH  = LEVELS * MAX_BLOCKS;
  localparam int TBL_AW     = LVL_W + BLK_W;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_POP,
    ST_LD_CMP,
    ST_LD_DONE,
    ST_Q_SRD,
    ST_Q_SPOS,
    ST_Q_SOUT,
    ST_B0_RD,
    ST_B0_WR,
    ST_BJ_RA,
    ST_BJ_RB,
    ST_BJ_VA,
    ST_BJ_VB,
    ST_BJ_WR,
    ST_QL_MA,
    ST_QL_MB,
    ST_QL_VA,
    ST_QL_VB,
    ST_QL_PICK,
    ST_QL_TA,
    ST_QL_TB,
    ST_QL_TVA,
    ST_QL_TVB,
    ST_QL_FIN
  } state_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } val_req_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [BLOCK_SIZE-1:0] wdata;
    logic [IDX_W-1:0]      raddr;
  } msk_req_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    logic [IDX_W-1:0]  wdata;
    logic [TBL_AW-1:0] raddr;
  } tbl_req_t;

  // Index of the highest set bit, zero for an empty mask.
  function automatic logic [MW-1:0] top_bit(input logic [BLOCK_SIZE-1:0] x);
    logic [MW-1:0] r;
    r = '0;
    for (int k = 0; k < BLOCK_SIZE; k++) begin
      if (x[k]) r = MW'(k);
    end
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] top_bit_blk(input logic [NB_W-1:0] x);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int k = 0; k < NB_W; k++) begin
      if (x[k]) r = LVL_W'(k);
    end
    return r;
  endfunction

  // Ones in the lowest len bits.
  function automatic logic [BLOCK_SIZE-1:0] low_mask(input logic [CNT_W-1:0] len);
    logic [BLOCK_SIZE-1:0] r;
    for (int k = 0; k < BLOCK_SIZE; k++) begin
      r[k] = (CNT_W'(k) < len);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/rmq_ram.sv -----
module rmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/rmq_core.sv -----
module rmq_core import rmq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              mode_i,
  input  logic signed [VAL_W-1:0] load_value_i,
  input  logic [IDX_W-1:0]        range_low_i,
  input  logic [IDX_W-1:0]        range_high_i,
  output logic                    valid_o,
  output logic signed [VAL_W-1:0] min_value_o,
  output logic                    status_o,
  output val_req_t                val_req_o,
  output msk_req_t                msk_req_o,
  output tbl_req_t                tbl_req_o,
  input  logic [VAL_W-1:0]        val_rdata_i,
  input  logic [BLOCK_SIZE-1:0]   msk_rdata_i,
  input  logic [IDX_W-1:0]        tbl_rdata_i
);

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q;
  logic [BLOCK_SIZE-1:0]   run_mask_q, m_q;
  logic                    built_q;
  logic signed [VAL_W-1:0] val_q, cur_q;
  logic [IDX_W-1:0]        lo_q, hi_q, a_q, b_q;
  logic [NB_W-1:0]         i_q;
  logic [LVL_W-1:0]        j_q;
  logic                    res_valid_q, res_status_q;
  logic signed [VAL_W-1:0] res_min_q;

  logic                    accept, full, bad_range, is_short;
  logic [CNT_W-1:0]        len_in, len_q;
  logic [BLOCK_SIZE-1:0]   low_bit;
  logic [MW-1:0]           pop_d;
  logic                    pop_go;
  logic signed [VAL_W-1:0] rd_val;
  logic                    pop_cmp;
  logic [NB_W-1:0]         nb, x_blk, y_blk, yy_blk, j_span;
  logic                    has_mid;
  logic [LVL_W-1:0]        jq;
  logic [NB_W:0]           span_j, span_jn, half_j, i_next;
  logic [LVL_W:0]          j_next;
  logic                    b0_more, b0_lvl, bj_more_i, bj_more_j;
  logic [IDX_W-1:0]        pos_short, pos_lo, pos_hi, bj_pick;
  logic signed [VAL_W-1:0] pair_min, fin_min;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (count_q >= CNT_W'(CAPACITY));
  assign len_in    = {1'b0, range_high_i} - {1'b0, range_low_i} + CNT_W'(1);
  assign bad_range = (range_low_i > range_high_i) || ({1'b0, range_high_i} >= count_q);
  assign is_short  = (len_in <= CNT_W'(BLOCK_SIZE));
  assign len_q     = {1'b0, hi_q} - {1'b0, lo_q} + CNT_W'(1);

  // Monotonic stack walk: the nearest older entry is the lowest set bit.
  assign low_bit = m_q & (~m_q + BLOCK_SIZE'(1));
  assign pop_d   = top_bit(low_bit);
  assign pop_go  = (m_q != '0) && (CNT_W'(pop_d) <= count_q);
  assign rd_val  = $signed(val_rdata_i);
  assign pop_cmp = (val_q < rd_val);

  assign nb     = count_q[CNT_W-1:MW];
  assign x_blk  = NB_W'(lo_q[IDX_W-1:MW]) + NB_W'(1);
  assign y_blk  = NB_W'(hi_q[IDX_W-1:MW]);
  assign yy_blk = y_blk - NB_W'(1);
  assign has_mid = (y_blk >= NB_W'(1)) && (x_blk + NB_W'(1) <= y_blk);
  assign jq     = top_bit_blk(yy_blk - x_blk + NB_W'(1));
  assign j_span = NB_W'(1) << jq;

  assign span_j    = (NB_W+1)'(1) << j_q;
  assign half_j    = (NB_W+1)'(1) << (j_q - LVL_W'(1));
  assign j_next    = {1'b0, j_q} + (LVL_W+1)'(1);
  assign span_jn   = (NB_W+1)'(1) << j_next;
  assign i_next    = {1'b0, i_q} + (NB_W+1)'(1);
  assign b0_more   = (i_next < {1'b0, nb});
  assign b0_lvl    = ({1'b0, nb} >= (NB_W+1)'(2));
  assign bj_more_i = (i_next + span_j <= {1'b0, nb});
  assign bj_more_j = (j_next < (LVL_W+1)'(LEVELS)) && (span_jn <= {1'b0, nb});

  assign pos_short = hi_q - IDX_W'(top_bit(msk_rdata_i & low_mask(len_q)));
  assign pos_lo    = lo_q + IDX_W'(BLOCK_SIZE - 1) - IDX_W'(top_bit(msk_rdata_i));
  assign pos_hi    = hi_q - IDX_W'(top_bit(msk_rdata_i));
  assign bj_pick   = (val_q < rd_val) ? a_q : b_q;
  assign pair_min  = (val_q < rd_val) ? val_q : rd_val;
  assign fin_min   = (cur_q < pair_min) ? cur_q : pair_min;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && mode_i == MODE_LOAD && !full) begin
          state_d = ST_LD_POP;
        end else if (accept && mode_i == MODE_QUERY && !bad_range) begin
          if (is_short)      state_d = ST_Q_SRD;
          else if (built_q)  state_d = ST_QL_MA;
          else               state_d = ST_B0_RD;
        end
      end
      ST_LD_POP:  state_d = pop_go ? ST_LD_CMP : ST_LD_DONE;
      ST_LD_CMP:  state_d = pop_cmp ? ST_LD_POP : ST_LD_DONE;
      ST_LD_DONE: state_d = ST_IDLE;
      ST_Q_SRD:   state_d = ST_Q_SPOS;
      ST_Q_SPOS:  state_d = ST_Q_SOUT;
      ST_Q_SOUT:  state_d = ST_IDLE;
      ST_B0_RD:   state_d = ST_B0_WR;
      ST_B0_WR: begin
        if (b0_more)     state_d = ST_B0_RD;
        else if (b0_lvl) state_d = ST_BJ_RA;
        else             state_d = ST_QL_MA;
      end
      ST_BJ_RA:   state_d = ST_BJ_RB;
      ST_BJ_RB:   state_d = ST_BJ_VA;
      ST_BJ_VA:   state_d = ST_BJ_VB;
      ST_BJ_VB:   state_d = ST_BJ_WR;
      ST_BJ_WR:   state_d = (bj_more_i || bj_more_j) ? ST_BJ_RA : ST_QL_MA;
      ST_QL_MA:   state_d = ST_QL_MB;
      ST_QL_MB:   state_d = ST_QL_VA;
      ST_QL_VA:   state_d = ST_QL_VB;
      ST_QL_VB:   state_d = ST_QL_PICK;
      ST_QL_PICK: state_d = has_mid ? ST_QL_TA : ST_IDLE;
      ST_QL_TA:   state_d = ST_QL_TB;
      ST_QL_TB:   state_d = ST_QL_TVA;
      ST_QL_TVA:  state_d = ST_QL_TVB;
      ST_QL_TVB:  state_d = ST_QL_FIN;
      ST_QL_FIN:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Memory requests
  always_comb begin
    val_req_o = '0;
    msk_req_o = '0;
    tbl_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        val_req_o.we    = accept && mode_i == MODE_LOAD && !full;
        val_req_o.waddr = count_q[IDX_W-1:0];
        val_req_o.wdata = load_value_i;
      end
      ST_LD_POP:  val_req_o.raddr = count_q[IDX_W-1:0] - IDX_W'(pop_d);
      ST_LD_DONE: begin
        msk_req_o.we    = 1'b1;
        msk_req_o.waddr = count_q[IDX_W-1:0];
        msk_req_o.wdata = m_q | BLOCK_SIZE'(1);
      end
      ST_Q_SRD:   msk_req_o.raddr = hi_q;
      ST_Q_SPOS:  val_req_o.raddr = pos_short;
      ST_B0_RD:   msk_req_o.raddr = {i_q[BLK_W-1:0], {MW{1'b1}}};
      ST_B0_WR: begin
        tbl_req_o.we    = 1'b1;
        tbl_req_o.waddr = {LVL_W'(0), i_q[BLK_W-1:0]};
        tbl_req_o.wdata = {i_q[BLK_W-1:0], {MW{1'b1}}} - IDX_W'(top_bit(msk_rdata_i));
      end
      ST_BJ_RA:   tbl_req_o.raddr = {j_q - LVL_W'(1), i_q[BLK_W-1:0]};
      ST_BJ_RB:   tbl_req_o.raddr = {j_q - LVL_W'(1), BLK_W'(i_next - (NB_W+1)'(1) + half_j)};
      ST_BJ_VA:   val_req_o.raddr = a_q;
      ST_BJ_VB:   val_req_o.raddr = b_q;
      ST_BJ_WR: begin
        tbl_req_o.we    = 1'b1;
        tbl_req_o.waddr = {j_q, i_q[BLK_W-1:0]};
        tbl_req_o.wdata = bj_pick;
      end
      ST_QL_MA:   msk_req_o.raddr = lo_q + IDX_W'(BLOCK_SIZE - 1);
      ST_QL_MB:   msk_req_o.raddr = hi_q;
      ST_QL_VA:   val_req_o.raddr = a_q;
      ST_QL_VB:   val_req_o.raddr = b_q;
      ST_QL_TA:   tbl_req_o.raddr = {jq, x_blk[BLK_W-1:0]};
      ST_QL_TB:   tbl_req_o.raddr = {jq, BLK_W'(yy_blk - j_span + NB_W'(1))};
      ST_QL_TVA:  val_req_o.raddr = a_q;
      ST_QL_TVB:  val_req_o.raddr = b_q;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      run_mask_q   <= '0;
      built_q      <= 1'b0;
      res_valid_q  <= 1'b0;
      res_status_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept && mode_i == MODE_CLEAR) begin
            count_q    <= '0;
            run_mask_q <= '0;
            built_q    <= 1'b0;
          end
          if (accept && mode_i == MODE_QUERY && bad_range) begin
            res_valid_q  <= 1'b1;
            res_status_q <= 1'b1;
          end
        end
        ST_LD_DONE: begin
          run_mask_q <= m_q | BLOCK_SIZE'(1);
          count_q    <= count_q + CNT_W'(1);
          built_q    <= 1'b0;
        end
        ST_B0_WR: if (!b0_more && !b0_lvl) built_q <= 1'b1;
        ST_BJ_WR: if (!bj_more_i && !bj_more_j) built_q <= 1'b1;
        ST_Q_SOUT, ST_QL_FIN: begin
          res_valid_q  <= 1'b1;
          res_status_q <= 1'b0;
        end
        ST_QL_PICK: if (!has_mid) begin
          res_valid_q  <= 1'b1;
          res_status_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        val_q     <= load_value_i;
        m_q       <= run_mask_q << 1;
        lo_q      <= range_low_i;
        hi_q      <= range_high_i;
        i_q       <= '0;
        res_min_q <= '0;
      end
      ST_LD_CMP: if (pop_cmp) m_q <= m_q & (m_q - BLOCK_SIZE'(1));
      ST_Q_SOUT: res_min_q <= rd_val;
      ST_B0_WR: begin
        if (b0_more) begin
          i_q <= i_next[NB_W-1:0];
        end else begin
          i_q <= '0;
          j_q <= LVL_W'(1);
        end
      end
      ST_BJ_RB:   a_q <= tbl_rdata_i;
      ST_BJ_VA:   b_q <= tbl_rdata_i;
      ST_BJ_VB:   val_q <= rd_val;
      ST_BJ_WR: begin
        if (bj_more_i) begin
          i_q <= i_next[NB_W-1:0];
        end else begin
          i_q <= '0;
          j_q <= j_next[LVL_W-1:0];
        end
      end
      ST_QL_MB:   a_q <= pos_lo;
      ST_QL_VA:   b_q <= pos_hi;
      ST_QL_VB:   val_q <= rd_val;
      ST_QL_PICK: begin
        cur_q     <= pair_min;
        res_min_q <= pair_min;
      end
      ST_QL_TB:   a_q <= tbl_rdata_i;
      ST_QL_TVA:  b_q <= tbl_rdata_i;
      ST_QL_TVB:  val_q <= rd_val;
      ST_QL_FIN:  res_min_q <= fin_min;
      default: ;
    endcase
  end

  assign valid_o     = res_valid_q;
  assign min_value_o = res_min_q;
  assign status_o    = res_status_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY)) else $error("count beyond capacity");
  a_mask_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_mask_q[0] == (count_q != '0)) else $error("running mask out of step with count");
  a_load_unbuilds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LD_DONE |=> !built_q) else $error("table still marked built after load");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o |-> min_value_o == '0) else $error("error word with nonzero value");

endmodule

// ----- hw/rtl/range_minimum_query_engine.sv -----
// Range minimum query engine. Drive a word with start high; it is taken at
// any edge where busy is low. Mode 0 appends load_value_i (dropped once 1024
// values are held), mode 2 empties the array, mode 1 queries the inclusive
// range [range_low_i, range_high_i]. Every query answers with exactly one
// valid_o pulse carrying min_value_o and status_o; the result is shown for one
// cycle only and cannot be stalled, so capture it on the pulse. A bad range
// (reversed, or past the last stored value) answers in the cycle after accept
// with status 1 and value 0, leaving busy low. Each memory has a single read
// port; a query answers in the same cycle that busy falls. A query of at most
// 32 values reads the stack mask at its upper end, then the value it points
// to; a longer query reads the masks and values at both ends, and looks up its
// middle blocks in the block table when it has any. The first long query after
// any load or clear first rebuilds that table: one entry per full block of 32
// values, then each entry of each higher level. A load walks the monotonic
// stack, popping each value larger than the new one (at most 31), until the
// stack runs empty or it meets a value no larger. Clears, dropped loads and
// unused modes leave busy low.
module range_minimum_query_engine import rmq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              mode_i,
  input  logic signed [VAL_W-1:0] load_value_i,
  input  logic [IDX_W-1:0]        range_low_i,
  input  logic [IDX_W-1:0]        range_high_i,
  output logic                    valid_o,
  output logic signed [VAL_W-1:0] min_value_o,
  output logic                    status_o
);

  val_req_t              val_req;
  msk_req_t              msk_req;
  tbl_req_t              tbl_req;
  logic [VAL_W-1:0]      val_rdata;
  logic [BLOCK_SIZE-1:0] msk_rdata;
  logic [IDX_W-1:0]      tbl_rdata;

  // Sequencer: load stack walk, table build and query steps.
  rmq_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .load_value_i (load_value_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .valid_o      (valid_o),
    .min_value_o  (min_value_o),
    .status_o     (status_o),
    .val_req_o    (val_req),
    .msk_req_o    (msk_req),
    .tbl_req_o    (tbl_req),
    .val_rdata_i  (val_rdata),
    .msk_rdata_i  (msk_rdata),
    .tbl_rdata_i  (tbl_rdata)
  );

  // Stored values, one per position.
  rmq_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_req.we),
    .waddr_i (val_req.waddr),
    .wdata_i (val_req.wdata),
    .raddr_i (val_req.raddr),
    .rdata_o (val_rdata)
  );

  // Stack masks: bit d marks position i-d on the window's increasing stack.
  rmq_ram #(.WIDTH(BLOCK_SIZE), .DEPTH(CAPACITY)) u_msk_ram (
    .clk_i   (clk_i),
    .we_i    (msk_req.we),
    .waddr_i (msk_req.waddr),
    .wdata_i (msk_req.wdata),
    .raddr_i (msk_req.raddr),
    .rdata_o (msk_rdata)
  );

  // Sparse table of block-minimum positions, addressed {level, block}.
  rmq_ram #(.WIDTH(IDX_W), .DEPTH(TBL_DEPTH)) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_req.we),
    .waddr_i (tbl_req.waddr),
    .wdata_i (tbl_req.wdata),
    .raddr_i (tbl_req.raddr),
    .rdata_o (tbl_rdata)
  );

endmodule

// ----- test/range_minimum_query_engine_tb.sv -----
module range_minimum_query_engine_tb import rmq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Mode 3 has no name in the package; the engine ignores it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Longest quiet stretch: a table rebuild walks every level of the block table.
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [1:0]              mode;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        lo;
    logic [IDX_W-1:0]        hi;
  } word_t;

  typedef struct {
    logic signed [VAL_W-1:0] min_value;
    logic                    status;
  } answer_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [1:0]              mode_i;
  logic signed [VAL_W-1:0] load_value_i;
  logic [IDX_W-1:0]        range_low_i;
  logic [IDX_W-1:0]        range_high_i;
  logic                    valid_o;
  logic signed [VAL_W-1:0] min_value_o;
  logic                    status_o;

  range_minimum_query_engine uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .load_value_i (load_value_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .valid_o      (valid_o),
    .min_value_o  (min_value_o),
    .status_o     (status_o)
  );

  word_t   pending_words[$];
  answer_t expected_minima[$];

  // Shadow copy of the stored array, kept by the predictor.
  logic signed [VAL_W-1:0] shadow_values[CAPACITY];
  int                      shadow_count = 0;

  int  mismatches = 0;
  bit  failed = 1'b0;
  int  gap_left;
  bit  burst;
  int  quiet_cycles;
  int  gen_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Apply one accepted word to the shadow array; queue an answer for queries.
  task automatic apply_word(input word_t w);
    answer_t a;
    a.min_value = '0;
    a.status    = 1'b0;
    case (w.mode)
      MODE_LOAD: begin
        if (shadow_count < CAPACITY) begin
          shadow_values[shadow_count] = w.value;
          shadow_count++;
        end
      end
      MODE_CLEAR: shadow_count = 0;
      MODE_QUERY: begin
        if (w.lo > w.hi || int'(w.hi) >= shadow_count) begin
          a.status = 1'b1;
        end else begin
          a.min_value = shadow_values[w.lo];
          for (int k = int'(w.lo) + 1; k <= int'(w.hi); k++) begin
            if (shadow_values[k] < a.min_value) a.min_value = shadow_values[k];
          end
        end
        expected_minima.insert(expected_minima.size(), a);
      end
      default: ;
    endcase
  endtask

  task automatic push_word(input logic [1:0] mode, input logic signed [VAL_W-1:0] value,
                           input int lo, input int hi);
    word_t w;
    w.mode  = mode;
    w.value = value;
    w.lo    = IDX_W'(lo);
    w.hi    = IDX_W'(hi);
    pending_words.insert(pending_words.size(), w);
    if (mode == MODE_LOAD && gen_count < CAPACITY) gen_count++;
    if (mode == MODE_CLEAR) gen_count = 0;
  endtask

  function automatic logic signed [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 5))
      0: return VAL_W'($urandom_range(0, 7));
      1: return -VAL_W'($urandom_range(0, 7));
      2: return {1'b1, {(VAL_W-1){1'b0}}};
      3: return {1'b0, {(VAL_W-1){1'b1}}};
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal ranges, short and long, with some reversed or past the end.
  task automatic push_query();
    int lo, hi;
    if (gen_count == 0 || $urandom_range(0, 9) == 0) begin
      lo = $urandom_range(0, CAPACITY - 1);
      hi = $urandom_range(0, CAPACITY - 1);
    end else begin
      lo = $urandom_range(0, gen_count - 1);
      if ($urandom_range(0, 1) == 0)
        hi = lo + $urandom_range(0, BLOCK_SIZE - 1);
      else
        hi = $urandom_range(lo, gen_count - 1);
      if (hi >= gen_count) hi = gen_count - 1;
    end
    push_word(MODE_QUERY, $urandom, lo, hi);
  endtask

  task automatic build_stimulus();
    int n;
    // Directed: empty array, extremes, ignored mode, reversed and past-end ranges.
    push_word(MODE_QUERY, 0, 0, 0);
    push_word(MODE_UNUSED, 5, 0, 0);
    push_word(MODE_LOAD, {1'b1, {(VAL_W-1){1'b0}}}, 0, 0);
    push_word(MODE_LOAD, {1'b0, {(VAL_W-1){1'b1}}}, 0, 0);
    push_word(MODE_LOAD, 0, 0, 0);
    push_word(MODE_LOAD, -1, 0, 0);
    push_word(MODE_QUERY, 0, 0, 3);
    push_word(MODE_QUERY, 0, 1, 3);
    push_word(MODE_QUERY, 0, 3, 3);
    push_word(MODE_QUERY, 0, 3, 1);
    push_word(MODE_QUERY, 0, 0, 4);
    push_word(MODE_QUERY, 0, CAPACITY - 1, CAPACITY - 1);
    push_word(MODE_CLEAR, 0, 0, 0);
    push_word(MODE_QUERY, 0, 0, 0);
    for (int k = 0; k < 70; k++) push_word(MODE_LOAD, 100 - k, 0, 0);
    push_word(MODE_QUERY, 0, 0, 69);
    push_word(MODE_QUERY, 0, 5, 68);
    push_word(MODE_QUERY, 0, 31, 32);
    // Random: load a batch, then hit it with queries; clear now and then.
    repeat (4) begin
      if ($urandom_range(0, 2) == 0) push_word(MODE_CLEAR, 0, 0, 0);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 12);
      repeat (n) push_word(MODE_LOAD, draw_value(), 0, 0);
      repeat ($urandom_range(3, 10)) push_query();
      if ($urandom_range(0, 3) == 0) push_word(MODE_UNUSED, $urandom, $urandom, $urandom);
    end
    // Fill to capacity, overrun it, and query across the whole array.
    push_word(MODE_CLEAR, 0, 0, 0);
    repeat (CAPACITY + 3) push_word(MODE_LOAD, draw_value(), 0, 0);
    push_word(MODE_QUERY, 0, 0, CAPACITY - 1);
    push_word(MODE_QUERY, 0, CAPACITY - 1, CAPACITY - 1);
    repeat (60) push_query();
  endtask

  // Driver: present a word, hold it until taken, then wait a drawn gap or go straight on.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start        <= 1'b0;
      mode_i       <= MODE_LOAD;
      load_value_i <= '0;
      range_low_i  <= '0;
      range_high_i <= '0;
      gap_left     <= 0;
      burst        <= 1'b0;
    end else if (start && !busy) begin
      apply_word(pending_words.pop_front());
      if ($urandom_range(0, 39) == 0) burst <= ~burst;
      if (burst || $urandom_range(0, 7) == 0) begin
        // Keep start high and advance straight to the next word.
        if (pending_words.size() > 0) begin
          mode_i       <= pending_words[0].mode;
          load_value_i <= pending_words[0].value;
          range_low_i  <= pending_words[0].lo;
          range_high_i <= pending_words[0].hi;
        end else begin
          start <= 1'b0;
        end
      end else begin
        start    <= 1'b0;
        gap_left <= $urandom_range(0, 7);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_words.size() > 0) begin
        start        <= 1'b1;
        mode_i       <= pending_words[0].mode;
        load_value_i <= pending_words[0].value;
        range_low_i  <= pending_words[0].lo;
        range_high_i <= pending_words[0].hi;
      end
    end
  end

  // Monitor: check each answer pulse against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_minima.size() == 0) begin
        failed = 1'b1;
        if (mismatches < 10)
          $display("unexpected answer: min %0d status %0d", min_value_o, status_o);
        mismatches++;
      end else begin
        answer_t e;
        e = expected_minima.pop_front();
        if (e.min_value !== min_value_o || e.status !== status_o) begin
          failed = 1'b1;
          if (mismatches < 10)
            $display("mismatch: expected min %0d status %0d, got min %0d status %0d",
                     e.min_value, e.status, min_value_o, status_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles with neither a word taken nor an answer seen.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    gen_count = 0;
    rst_ni    = 1'b0;
    build_stimulus();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Hold until every word is taken and every answer is in.
    while (pending_words.size() > 0 || start || expected_minima.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed && expected_minima.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
